/* design/gap_buffer_engine_core_macros.svh */
// assertion macros shared by the gap buffer engine
`ifndef GAP_BUFFER_ENGINE_CORE_MACROS_SVH
`define GAP_BUFFER_ENGINE_CORE_MACROS_SVH

// condition holds at every clock edge outside reset
`define GBE_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define GBE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define GBE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/gbe_pkg.sv */
// types and constants of the gap buffer engine
`default_nettype none

package gbe_pkg;

    localparam int CAPACITY_DEF = 4096;
    localparam int POS_W        = 13;
    localparam int BYTE_W       = 8;
    localparam int OP_W         = 2;
    localparam int STAT_W       = 2;

    typedef enum logic [OP_W-1:0] {
        OP_READ   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BOUNDS = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_READ_WAIT,
        S_MOVE,
        S_COMMIT,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic    latch;
        logic    issue_read;
        logic    step_right;
        logic    step_left;
        logic    commit_insert;
        logic    commit_delete;
        logic    clear_gap;
        logic    load_out;
        logic    use_rd;
        t_status res_status;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_opcode op;
        logic    rd_bad;
        logic    ins_bad;
        logic    ins_full;
        logic    del_bad;
        logic    del_empty;
        logic    at_target;
        logic    below_target;
        logic    out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

/* design/gbe_req_if.sv */
// request channel of the gap buffer engine
`default_nettype none

interface gbe_req_if;
    import gbe_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [POS_W-1:0]  position;
    logic [POS_W-1:0]  range_end;
    logic [BYTE_W-1:0] new_byte;

    modport source (output valid, output opcode, output position, output range_end,
                    output new_byte, input ready);
    modport sink   (input valid, input opcode, input position, input range_end,
                    input new_byte, output ready);
endinterface

`default_nettype wire

/* design/gbe_rsp_if.sv */
// result channel of the gap buffer engine
`default_nettype none

interface gbe_rsp_if;
    import gbe_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] read_byte;
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  text_length;

    modport source (output valid, output read_byte, output status, output text_length,
                    input ready);
    modport sink   (input valid, input read_byte, input status, input text_length,
                    output ready);
endinterface

`default_nettype wire

/* design/gap_buffer_engine_core.sv */
// gap buffer engine: fixed-capacity byte gap buffer with read, insert, delete, clear
//
// Requests arrive on i_req (opcode, position, range_end, new_byte) and are taken
// when valid and ready are both high; every request gives exactly one result on
// o_rsp (read_byte, status, text_length), held in an output register until taken.
// One request is worked on at a time; a new one is taken while the last result
// still waits in the output register.
// A read passes S_EVAL, S_READ_WAIT and S_DONE; a clear, an empty delete and every
// rejected request pass S_EVAL and S_DONE; an insert or delete passes S_EVAL, then
// S_MOVE, where the gap moves one byte per cycle through the single-port-pair text
// store, then S_COMMIT and S_DONE. The next request is taken the cycle after its
// result is loaded.
// Reset makes the whole store one gap (empty text); store contents are not
// cleared and no clearing pass runs, since only written bytes are ever read.
// When the receiver stalls, a finished result waits in the engine until the
// output register frees up, and no further request is taken meanwhile.
`default_nettype none
`include "gap_buffer_engine_core_macros.svh"

module gap_buffer_engine_core #(
    parameter int CAPACITY = gbe_pkg::CAPACITY_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    gbe_req_if.sink   i_req,
    gbe_rsp_if.source o_rsp
);
    import gbe_pkg::*;

    t_dp_cmd    cmd;
    t_dp_sts    sts;
    logic       in_ready;
    logic [5:0] store_ops;

    // controller
    gbe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath
    gbe_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_opcode      (i_req.opcode),
        .i_position    (i_req.position),
        .i_range_end   (i_req.range_end),
        .i_new_byte    (i_req.new_byte),
        .o_out_valid   (o_rsp.valid),
        .i_out_ready   (o_rsp.ready),
        .o_read_byte   (o_rsp.read_byte),
        .o_status      (o_rsp.status),
        .o_text_length (o_rsp.text_length)
    );

    assign i_req.ready = in_ready;

    // store operations issued this cycle
    assign store_ops = {cmd.issue_read, cmd.step_right, cmd.step_left,
                        cmd.commit_insert, cmd.commit_delete, cmd.clear_gap};

    // checks
    `GBE_ASSERT_ALWAYS(a_one_store_op, i_clk, i_rst_n, ($onehot0(store_ops)), "more than one store operation at once")
    `GBE_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, cmd.load_out, o_rsp.valid, "loaded result not shown")
    `GBE_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, (i_req.valid && i_req.ready), !i_req.ready, "request taken while busy")
    `GBE_ASSERT_SAME(a_step_needs_move, i_clk, i_rst_n, (cmd.step_right || cmd.step_left), !sts.at_target, "gap stepped past target")

endmodule

`default_nettype wire

/* design/gbe_datapath.sv */
// gap buffer datapath: text store, gap pointers, bounds checks, result register
`default_nettype none

module gbe_datapath #(
    parameter int CAPACITY = gbe_pkg::CAPACITY_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire gbe_pkg::t_dp_cmd           i_cmd,
    output gbe_pkg::t_dp_sts                o_sts,
    input  wire logic [gbe_pkg::OP_W-1:0]   i_opcode,
    input  wire logic [gbe_pkg::POS_W-1:0]  i_position,
    input  wire logic [gbe_pkg::POS_W-1:0]  i_range_end,
    input  wire logic [gbe_pkg::BYTE_W-1:0] i_new_byte,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [gbe_pkg::BYTE_W-1:0]      o_read_byte,
    output logic [gbe_pkg::STAT_W-1:0]      o_status,
    output logic [gbe_pkg::POS_W-1:0]       o_text_length
);
    import gbe_pkg::*;

    localparam int PW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = (PW > POS_W) ? PW : POS_W;
    localparam logic [PW-1:0] CapW = PW'(CAPACITY);

    // text store
    logic [BYTE_W-1:0] r_mem [CAPACITY];

    // latched request
    t_opcode           r_op;
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  r_rend;
    logic [BYTE_W-1:0] r_byte;

    // gap pointers
    logic [PW-1:0] r_gb, n_gb;
    logic [PW-1:0] r_gf, n_gf;

    // copy pipeline
    logic              r_wr_pend;
    logic [AW-1:0]     r_wr_addr;
    logic [BYTE_W-1:0] r_rd_data;

    // result register
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    t_status           r_out_status;
    logic [POS_W-1:0]  r_out_len;

    logic [PW-1:0]     gap_width;
    logic [PW-1:0]     text_len;
    logic [CW-1:0]     pos_x, rend_x, len_x, gb_x, rd_idx, del_cnt;
    logic [PW-1:0]     target;
    logic [PW-1:0]     gb_m1, gf_m1;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic [AW-1:0]     copy_dst;

    // lengths and checks
    always_comb begin
        gap_width = r_gf - r_gb;
        text_len = CapW - gap_width;
        pos_x    = CW'(r_pos);
        rend_x   = CW'(r_rend);
        len_x    = CW'(text_len);
        gb_x     = CW'(r_gb);
        target   = pos_x[PW-1:0];
        gb_m1    = r_gb - PW'(1);
        gf_m1    = r_gf - PW'(1);
        del_cnt  = rend_x - pos_x;
        rd_idx   = (pos_x >= gb_x) ? (pos_x + CW'(gap_width)) : pos_x;
    end

    assign o_sts.op           = r_op;
    assign o_sts.rd_bad       = (pos_x >= len_x);
    assign o_sts.ins_bad      = (pos_x > len_x);
    assign o_sts.ins_full     = (text_len == CapW);
    assign o_sts.del_bad      = (pos_x > rend_x) || (rend_x > len_x);
    assign o_sts.del_empty    = (pos_x == rend_x);
    assign o_sts.at_target    = (r_gb == target);
    assign o_sts.below_target = (r_gb < target);
    assign o_sts.out_free     = !r_out_valid || i_out_ready;

    // memory port selection
    always_comb begin
        rd_en    = 1'b0;
        rd_addr  = rd_idx[AW-1:0];
        copy_dst = r_gb[AW-1:0];
        priority if (i_cmd.issue_read) begin
            rd_en = 1'b1;
        end else if (i_cmd.step_right) begin
            rd_en   = 1'b1;
            rd_addr = r_gf[AW-1:0];
        end else if (i_cmd.step_left) begin
            rd_en    = 1'b1;
            rd_addr  = gb_m1[AW-1:0];
            copy_dst = gf_m1[AW-1:0];
        end
        wr_en   = r_wr_pend || i_cmd.commit_insert;
        wr_addr = r_wr_pend ? r_wr_addr : r_gb[AW-1:0];
        wr_data = r_wr_pend ? r_rd_data : r_byte;
    end

    // gap pointer update
    always_comb begin
        n_gb = r_gb;
        n_gf = r_gf;
        priority if (i_cmd.clear_gap) begin
            n_gb = '0;
            n_gf = CapW;
        end else if (i_cmd.step_right) begin
            n_gb = r_gb + PW'(1);
            n_gf = r_gf + PW'(1);
        end else if (i_cmd.step_left) begin
            n_gb = gb_m1;
            n_gf = gf_m1;
        end else if (i_cmd.commit_insert) begin
            n_gb = r_gb + PW'(1);
        end else if (i_cmd.commit_delete) begin
            n_gf = r_gf + del_cnt[PW-1:0];
        end
    end

    // store write port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    // store read port
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gb        <= '0;
            r_gf        <= CapW;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_gb      <= n_gb;
            r_gf      <= n_gf;
            r_wr_pend <= i_cmd.step_right || i_cmd.step_left;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op   <= t_opcode'(i_opcode);
            r_pos  <= i_position;
            r_rend <= i_range_end;
            r_byte <= i_new_byte;
        end
        r_wr_addr <= copy_dst;
        if (i_cmd.load_out) begin
            r_out_byte   <= i_cmd.use_rd ? r_rd_data : '0;
            r_out_status <= i_cmd.res_status;
            r_out_len    <= len_x[POS_W-1:0];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_byte   = r_out_byte;
    assign o_status      = r_out_status;
    assign o_text_length = r_out_len;

endmodule

`default_nettype wire

/* design/gbe_ctrl.sv */
// gap buffer controller state machine
`default_nettype none

module gbe_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire gbe_pkg::t_dp_sts i_sts,
    output gbe_pkg::t_dp_cmd      o_cmd
);
    import gbe_pkg::*;

    t_state  r_state, n_state;
    t_status r_res_status, n_res_status;
    logic    r_use_rd, n_use_rd;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_res_status <= ST_OK;
            r_use_rd     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_res_status <= n_res_status;
            r_use_rd     <= n_use_rd;
        end
    end

    // next state and commands
    always_comb begin
        n_state      = r_state;
        n_res_status = r_res_status;
        n_use_rd     = r_use_rd;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        o_cmd.res_status = r_res_status;
        o_cmd.use_rd     = r_use_rd;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
                if (i_in_valid) begin
                    n_state      = S_EVAL;
                    n_res_status = ST_OK;
                    n_use_rd     = 1'b0;
                end
            end
            S_EVAL: begin
                unique case (i_sts.op)
                    OP_READ: begin
                        if (i_sts.rd_bad) begin
                            n_res_status = ST_BOUNDS;
                            n_state      = S_DONE;
                        end else begin
                            o_cmd.issue_read = 1'b1;
                            n_use_rd         = 1'b1;
                            n_state          = S_READ_WAIT;
                        end
                    end
                    OP_INSERT: begin
                        priority if (i_sts.ins_bad) begin
                            n_res_status = ST_BOUNDS;
                            n_state      = S_DONE;
                        end else if (i_sts.ins_full) begin
                            n_res_status = ST_FULL;
                            n_state      = S_DONE;
                        end else begin
                            n_state = S_MOVE;
                        end
                    end
                    OP_DELETE: begin
                        priority if (i_sts.del_bad) begin
                            n_res_status = ST_BOUNDS;
                            n_state      = S_DONE;
                        end else if (i_sts.del_empty) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_MOVE;
                        end
                    end
                    OP_CLEAR: begin
                        o_cmd.clear_gap = 1'b1;
                        n_state         = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_READ_WAIT: begin
                n_state = S_DONE;
            end
            // one byte crosses the gap per cycle
            S_MOVE: begin
                priority if (i_sts.at_target) begin
                    n_state = S_COMMIT;
                end else if (i_sts.below_target) begin
                    o_cmd.step_right = 1'b1;
                end else begin
                    o_cmd.step_left = 1'b1;
                end
            end
            S_COMMIT: begin
                o_cmd.commit_insert = (i_sts.op == OP_INSERT);
                o_cmd.commit_delete = (i_sts.op != OP_INSERT);
                n_state             = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
